// ===== rtl/core/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer package
// Shared types, register indexes, reset values and default sizes.
// ----------------------------------------------------------------------------
package lps_pkg;

	// Default sizes of the pattern store and the LED bank
	localparam int DEF_MAX_PATTERNS = 8;
	localparam int DEF_MAX_STEPS    = 64;
	localparam int DEF_LED_COUNT    = 7;

	// Configuration register indexes
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MODE_COUNT     = 1'd1;
	localparam int CFG_DATA_W = 8;

	// Register reset values
	localparam logic [7:0] RST_DEBOUNCE_LIMIT = 8'd196;
	localparam logic [3:0] RST_MODE_COUNT     = 4'd5;

	// Request kinds
	localparam logic FUNC_TICK  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	// One stored pattern entry
	typedef struct packed {
		logic [2:0]  led_sel;
		logic        level;
		logic [15:0] hold;
		logic        last;
	} entry_t;

endpackage

// ===== rtl/core/led_pattern_sequencer.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer
// Plays table-driven LED patterns, one entry per tick once the previous hold expires,
// with a debounced mode button that cycles through the stored patterns.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | func, button_down, ms_strobe, entry_*
//  out     | output    | out_valid/out_stall| led_outputs, active_mode, next_position
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One request is taken every cycle while in_stall is low; it is held in the
// input stage and its result is registered once that stage advances. The
// pattern store is read ahead at the address that the state will hold.
// Reset clears all control state at once; the store needs no clearing pass.
// A stalled result holds in_stall high only while the input stage is full.
// ----------------------------------------------------------------------------
module led_pattern_sequencer #(
	parameter int MAX_PATTERNS = lps_pkg::DEF_MAX_PATTERNS,
	parameter int MAX_STEPS    = lps_pkg::DEF_MAX_STEPS,
	parameter int LED_COUNT    = lps_pkg::DEF_LED_COUNT,
	localparam int MODE_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1,
	localparam int STEP_W = $clog2(MAX_STEPS)
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// request channel
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic                         func,
	input  logic                         button_down,
	input  logic                         ms_strobe,
	input  logic [MODE_W-1:0]            entry_mode,
	input  logic [STEP_W-1:0]            entry_step,
	input  logic [2:0]                   entry_output,
	input  logic                         entry_level,
	input  logic [15:0]                  entry_wait,
	input  logic                         entry_final,
	// result channel
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [LED_COUNT-1:0]         led_outputs,
	output logic [MODE_W-1:0]            active_mode,
	output logic [STEP_W-1:0]            next_position,
	// configuration channel
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data
);

	localparam int DEPTH  = MAX_PATTERNS * MAX_STEPS;
	localparam int ADDR_W = $clog2(DEPTH);

	// configuration registers
	logic [7:0] limit_cfg_q;
	logic [3:0] mcount_cfg_q;

	// input stage
	logic               valid_s1;
	logic               func_s1;
	logic               button_s1;
	logic               ms_s1;
	logic [MODE_W-1:0]  emode_s1;
	logic [STEP_W-1:0]  estep_s1;
	lps_pkg::entry_t    entry_s1;

	// sequencer state
	logic [LED_COUNT-1:0] led_q;
	logic [7:0]           press_q;
	logic                 handled_q;
	logic [MODE_W-1:0]    mode_q;
	logic [STEP_W-1:0]    step_q;
	logic [15:0]          wait_q;
	logic                 out_valid_q;

	// pattern store, step-0 copy and bypass
	lps_pkg::entry_t mem [DEPTH];
	lps_pkg::entry_t row0_q [MAX_PATTERNS];
	lps_pkg::entry_t rd_q;
	lps_pkg::entry_t fwd_data_q;
	logic            fwd_q;

	logic               adv;
	logic               tick;
	logic               wr_en;
	logic [ADDR_W-1:0]  wr_addr;
	logic [ADDR_W-1:0]  rd_addr;
	lps_pkg::entry_t    cur_entry;
	lps_pkg::entry_t    sel_entry;

	logic [7:0]           limit;
	logic [4:0]           mcount;
	logic [7:0]           press_n;
	logic                 handled_base;
	logic                 pending;
	logic                 do_step;
	logic [4:0]           mode_inc;
	logic [MODE_W-1:0]    mode_alt;
	logic [LED_COUNT-1:0] led_base;
	logic [STEP_W:0]      step_inc;
	logic [STEP_W-1:0]    step_base;

	logic [LED_COUNT-1:0] led_n;
	logic [7:0]           press_d;
	logic                 handled_d;
	logic [MODE_W-1:0]    mode_d;
	logic [STEP_W-1:0]    step_d;
	logic [15:0]          wait_d;

	// handshake: the stage advances when the result slot is free or taken
	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !adv;
	assign out_valid = out_valid_q;
	assign cfg_ready = 1'b1;
	assign tick      = adv && (func_s1 == lps_pkg::FUNC_TICK);

	// write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_cfg_q  <= lps_pkg::RST_DEBOUNCE_LIMIT;
			mcount_cfg_q <= lps_pkg::RST_MODE_COUNT;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				lps_pkg::REG_DEBOUNCE_LIMIT: limit_cfg_q <= cfg_data;
				lps_pkg::REG_MODE_COUNT:     mcount_cfg_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// capture request payload
	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			func_s1          <= func;
			button_s1        <= button_down;
			ms_s1            <= ms_strobe;
			emode_s1         <= entry_mode;
			estep_s1         <= entry_step;
			entry_s1.led_sel <= entry_output;
			entry_s1.level   <= entry_level;
			entry_s1.hold    <= entry_wait;
			entry_s1.last    <= entry_final;
		end
	end

	// clamp configuration values
	always_comb begin
		limit  = (limit_cfg_q == 8'd0) ? 8'd1 : limit_cfg_q;
		if (mcount_cfg_q == 4'd0)
			mcount = 5'd1;
		else if (int'(mcount_cfg_q) > MAX_PATTERNS)
			mcount = 5'(MAX_PATTERNS);
		else
			mcount = {1'b0, mcount_cfg_q};
	end

	// debounce the button and pick the entry to apply
	assign cur_entry = fwd_q ? fwd_data_q : rd_q;

	always_comb begin
		if (button_s1) begin
			press_n      = (press_q < limit) ? press_q + 8'd1 : limit;
			handled_base = handled_q;
		end else begin
			press_n      = 8'd0;
			handled_base = 1'b0;
		end
		pending  = (press_n >= limit) && !handled_base;
		do_step  = (wait_q == 16'd0) || pending;
		mode_inc = 5'(mode_q) + 5'd1;
		mode_alt = (mode_inc >= mcount) ? '0 : MODE_W'(mode_inc);
		sel_entry = pending ? row0_q[mode_alt] : cur_entry;
		led_base  = pending ? '0 : led_q;
		step_base = pending ? '0 : step_q;
	end

	// apply the entry and advance the step
	always_comb begin
		led_n = led_base;
		for (int i = 0; i < LED_COUNT; i++) begin
			if (int'(sel_entry.led_sel) == i)
				led_n[i] = sel_entry.level;
		end
		step_inc = (STEP_W+1)'(step_base) + (STEP_W+1)'(1);
	end

	// next state
	always_comb begin
		press_d   = press_q;
		handled_d = handled_q;
		mode_d    = mode_q;
		step_d    = step_q;
		wait_d    = wait_q;
		if (tick) begin
			press_d   = press_n;
			handled_d = handled_base || pending;
			if (pending)
				mode_d = mode_alt;
			if (do_step) begin
				wait_d = sel_entry.hold;
				if (sel_entry.last || int'(step_inc) >= MAX_STEPS)
					step_d = '0;
				else
					step_d = STEP_W'(step_inc);
			end else if (ms_s1) begin
				wait_d = wait_q - 16'd1;
			end
		end
	end

	// update sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			led_q       <= '0;
			press_q     <= '0;
			handled_q   <= 1'b0;
			mode_q      <= '0;
			step_q      <= '0;
			wait_q      <= '0;
		end else begin
			if (in_valid && !in_stall)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
			if (tick && do_step)
				led_q <= led_n;
			press_q   <= press_d;
			handled_q <= handled_d;
			mode_q    <= mode_d;
			step_q    <= step_d;
			wait_q    <= wait_d;
		end
	end

	// store addressing
	assign wr_en   = adv && (func_s1 == lps_pkg::FUNC_WRITE)
		&& (int'(emode_s1) < MAX_PATTERNS) && (int'(estep_s1) < MAX_STEPS);
	assign wr_addr = ADDR_W'(ADDR_W'(emode_s1) * ADDR_W'(MAX_STEPS) + ADDR_W'(estep_s1));
	assign rd_addr = ADDR_W'(ADDR_W'(mode_d) * ADDR_W'(MAX_STEPS) + ADDR_W'(step_d));

	// write the store and prefetch the entry for the coming state
	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= entry_s1;
		rd_q       <= mem[rd_addr];
		fwd_data_q <= entry_s1;
		if (wr_en && estep_s1 == '0)
			row0_q[emode_s1] <= entry_s1;
	end

	// flag a write that lands on the prefetched address
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			fwd_q <= 1'b0;
		else
			fwd_q <= wr_en && (wr_addr == rd_addr);
	end

	// drive the result from the state registers
	assign led_outputs   = led_q;
	assign active_mode   = mode_q;
	assign next_position = step_q;

endmodule

// ===== rtl/core/lps_chk.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer checker
// Port-level assertions on the sequencer's handshakes and result timing.
// ----------------------------------------------------------------------------
module lps_chk #(
	parameter int MAX_PATTERNS = lps_pkg::DEF_MAX_PATTERNS,
	parameter int MAX_STEPS    = lps_pkg::DEF_MAX_STEPS,
	parameter int LED_COUNT    = lps_pkg::DEF_LED_COUNT,
	localparam int MODE_W = (MAX_PATTERNS > 1) ? $clog2(MAX_PATTERNS) : 1,
	localparam int STEP_W = $clog2(MAX_STEPS)
) (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic [LED_COUNT-1:0] led_outputs,
	input logic [MODE_W-1:0]    active_mode,
	input logic [STEP_W-1:0]    next_position
);

	// the input side only backs up behind a stalled result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("request stalled without a stalled result");

	// state only moves together with a new result
	a_state_result: assert property (@(posedge clk) disable iff (!arst_n)
		!($stable(led_outputs) && $stable(active_mode) && $stable(next_position))
		|-> out_valid)
		else $error("sequencer state changed without a result");

	// a stalled result stays offered
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	// a stalled result keeps its payload
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=>
		($stable(led_outputs) && $stable(active_mode) && $stable(next_position)))
		else $error("result payload changed while stalled");

endmodule

bind led_pattern_sequencer lps_chk #(
	.MAX_PATTERNS(MAX_PATTERNS),
	.MAX_STEPS   (MAX_STEPS),
	.LED_COUNT   (LED_COUNT)
) u_lps_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.led_outputs  (led_outputs),
	.active_mode  (active_mode),
	.next_position(next_position)
);

// ===== bench/led_pattern_sequencer_checker.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer checker
// Watches the request, result and configuration channels of the sequencer,
// keeps its own copy of the pattern table and play state, predicts the LED
// levels, mode and next position for every accepted request and compares
// them in order with the accepted results.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_checker #(
	parameter int MAX_PATTERNS = lps_pkg::DEF_MAX_PATTERNS,
	parameter int MAX_STEPS    = lps_pkg::DEF_MAX_STEPS,
	parameter int LED_COUNT    = lps_pkg::DEF_LED_COUNT,
	parameter int MODE_W       = $clog2(lps_pkg::DEF_MAX_PATTERNS),
	parameter int STEP_W       = $clog2(lps_pkg::DEF_MAX_STEPS)
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic                           in_stall,
	input  logic                           func,
	input  logic                           button_down,
	input  logic                           ms_strobe,
	input  logic [MODE_W-1:0]              entry_mode,
	input  logic [STEP_W-1:0]              entry_step,
	input  logic [2:0]                     entry_output,
	input  logic                           entry_level,
	input  logic [15:0]                    entry_wait,
	input  logic                           entry_final,
	input  logic                           out_valid,
	input  logic                           out_stall,
	input  logic [LED_COUNT-1:0]           led_outputs,
	input  logic [MODE_W-1:0]              active_mode,
	input  logic [STEP_W-1:0]              next_position,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [lps_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             pending_results,
	output int                             error_count
);

	localparam int ADDR_W = $clog2(MAX_PATTERNS*MAX_STEPS);

	typedef struct packed {
		logic [LED_COUNT-1:0] leds;
		logic [MODE_W-1:0]    mode;
		logic [STEP_W-1:0]    pos;
	} play_view_t;

	// Shadow of the pattern table and the play state
	lps_pkg::entry_t      pattern_mem [MAX_PATTERNS*MAX_STEPS];
	logic [LED_COUNT-1:0] led_q;
	logic [7:0]           press_cnt;
	logic                 press_done;
	logic [MODE_W-1:0]    mode_q;
	logic [STEP_W-1:0]    pos_q;
	logic [15:0]          hold_left;
	logic [7:0]           debounce_cfg;
	logic [3:0]           modes_cfg;

	play_view_t expected_views [$];
	int         errors;

	// Apply one request to the shadow state and return the view it leaves
	function automatic play_view_t play_request(input logic f, input logic btn,
			input logic ms, input logic [MODE_W-1:0] em, input logic [STEP_W-1:0] es,
			input logic [2:0] eo, input logic el, input logic [15:0] ew, input logic ef);
		int unsigned       limit;
		int unsigned       modes;
		int unsigned       nxt;
		logic              pending;
		logic [ADDR_W-1:0] addr;
		lps_pkg::entry_t   e;
		play_view_t        v;
		limit = (debounce_cfg == 8'd0) ? 32'd1 : 32'(debounce_cfg);
		modes = (modes_cfg == 4'd0) ? 32'd1 : 32'(modes_cfg);
		if (modes > MAX_PATTERNS)
			modes = MAX_PATTERNS;
		if (f == lps_pkg::FUNC_WRITE) begin
			e.led_sel = eo;
			e.level   = el;
			e.hold    = ew;
			e.last    = ef;
			addr = ADDR_W'(ADDR_W'(em) * ADDR_W'(MAX_STEPS) + ADDR_W'(es));
			pattern_mem[addr] = e;
		end else begin
			// debounce: count up to the limit, drop everything on release
			if (btn) begin
				if (32'(press_cnt) < limit)
					press_cnt = press_cnt + 8'd1;
				else
					press_cnt = 8'(limit);
			end else begin
				press_cnt  = '0;
				press_done = 1'b0;
			end
			pending = (32'(press_cnt) >= limit) && !press_done;
			if (hold_left == 16'd0 || pending) begin
				if (pending) begin
					nxt        = 32'(mode_q) + 32'd1;
					mode_q     = (nxt >= modes) ? '0 : MODE_W'(nxt);
					led_q      = '0;
					pos_q      = '0;
					press_done = 1'b1;
				end
				addr = ADDR_W'(ADDR_W'(mode_q) * ADDR_W'(MAX_STEPS) + ADDR_W'(pos_q));
				e = pattern_mem[addr];
				if (int'(e.led_sel) < LED_COUNT)
					led_q[e.led_sel] = e.level;
				hold_left = e.hold;
				pos_q = (e.last || int'(pos_q) == MAX_STEPS-1) ? '0 : pos_q + STEP_W'(1);
			end else if (ms) begin
				hold_left = hold_left - 16'd1;
			end
		end
		v.leds = led_q;
		v.mode = mode_q;
		v.pos  = pos_q;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		play_view_t got;
		play_view_t want;
		if (!arst_n) begin
			led_q        = '0;
			press_cnt    = '0;
			press_done   = 1'b0;
			mode_q       = '0;
			pos_q        = '0;
			hold_left    = '0;
			debounce_cfg = lps_pkg::RST_DEBOUNCE_LIMIT;
			modes_cfg    = lps_pkg::RST_MODE_COUNT;
			errors       = 0;
			expected_views.delete();
			pending_results <= 0;
			error_count     <= 0;
		end else begin
			// track register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					lps_pkg::REG_DEBOUNCE_LIMIT: debounce_cfg = cfg_data;
					lps_pkg::REG_MODE_COUNT:     modes_cfg = cfg_data[3:0];
					default: ;
				endcase
			end
			// predict each accepted request
			if (in_valid && !in_stall)
				expected_views.push_back(play_request(func, button_down, ms_strobe,
					entry_mode, entry_step, entry_output, entry_level, entry_wait,
					entry_final));
			// compare each accepted result with the oldest prediction
			if (out_valid && !out_stall) begin
				got.leds = led_outputs;
				got.mode = active_mode;
				got.pos  = next_position;
				if (expected_views.size() == 0) begin
					$display("%0t: unexpected result, expected none, got leds %h mode %0d pos %0d",
						$time, got.leds, got.mode, got.pos);
					errors++;
				end else begin
					want = expected_views.pop_front();
					if (got.leds !== want.leds) begin
						$display("%0t: led_outputs expected %h got %h", $time, want.leds, got.leds);
						errors++;
					end
					if (got.mode !== want.mode) begin
						$display("%0t: active_mode expected %0d got %0d", $time, want.mode, got.mode);
						errors++;
					end
					if (got.pos !== want.pos) begin
						$display("%0t: next_position expected %0d got %0d", $time, want.pos, got.pos);
						errors++;
					end
				end
			end
			pending_results <= expected_views.size();
			error_count     <= errors;
		end
	end

endmodule

// ===== bench/led_pattern_sequencer_tb.sv =====
// ----------------------------------------------------------------------------
// LED pattern sequencer testbench
// Loads pattern tables, plays them with ticks, millisecond strobes and
// debounced button presses under several register settings, with random
// gaps on both channels and one long result hold-off. The checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
module led_pattern_sequencer_tb;

	localparam int MODE_W      = $clog2(lps_pkg::DEF_MAX_PATTERNS);
	localparam int STEP_W      = $clog2(lps_pkg::DEF_MAX_STEPS);
	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           in_valid = 1'b0;
	logic                           in_stall;
	logic                           func = lps_pkg::FUNC_TICK;
	logic                           button_down = 1'b0;
	logic                           ms_strobe = 1'b0;
	logic [MODE_W-1:0]              entry_mode = '0;
	logic [STEP_W-1:0]              entry_step = '0;
	logic [2:0]                     entry_output = '0;
	logic                           entry_level = 1'b0;
	logic [15:0]                    entry_wait = '0;
	logic                           entry_final = 1'b0;
	logic                           out_valid;
	logic                           out_stall = 1'b0;
	logic [lps_pkg::DEF_LED_COUNT-1:0] led_outputs;
	logic [MODE_W-1:0]              active_mode;
	logic [STEP_W-1:0]              next_position;
	logic                           cfg_valid = 1'b0;
	logic                           cfg_ready;
	logic [lps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [lps_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	int          pending_results;
	int          error_count;
	int unsigned cycle_count = 0;
	int          items_sent = 0;
	int          debounce_now = int'(lps_pkg::RST_DEBOUNCE_LIMIT);
	bit          calm = 1'b0;
	bit          hold_armed = 1'b0;
	bit          hold_served = 1'b0;

	// Table entries written so far; reads of anything else must not happen
	bit entry_known [lps_pkg::DEF_MAX_PATTERNS][lps_pkg::DEF_MAX_STEPS];

	led_pattern_sequencer i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .button_down(button_down), .ms_strobe(ms_strobe),
		.entry_mode(entry_mode), .entry_step(entry_step), .entry_output(entry_output),
		.entry_level(entry_level), .entry_wait(entry_wait), .entry_final(entry_final),
		.out_valid(out_valid), .out_stall(out_stall),
		.led_outputs(led_outputs), .active_mode(active_mode), .next_position(next_position),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	led_pattern_sequencer_checker i_checker (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.func(func), .button_down(button_down), .ms_strobe(ms_strobe),
		.entry_mode(entry_mode), .entry_step(entry_step), .entry_output(entry_output),
		.entry_level(entry_level), .entry_wait(entry_wait), .entry_final(entry_final),
		.out_valid(out_valid), .out_stall(out_stall),
		.led_outputs(led_outputs), .active_mode(active_mode), .next_position(next_position),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.pending_results(pending_results), .error_count(error_count)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Abort a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 32'd1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Result side: random stalls, one long hold-off on request
	initial begin
		forever begin
			@(posedge clk);
			if (hold_armed && !hold_served) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_served = 1'b1;
			end else begin
				out_stall <= !calm && ($urandom_range(99) < 27);
			end
		end
	end

	// Offer one request, with random gaps ahead of it, and wait for accept
	task automatic send_request(input logic f, input logic btn, input logic ms,
			input logic [MODE_W-1:0] m, input logic [STEP_W-1:0] s, input logic [2:0] o,
			input logic lvl, input logic [15:0] hold_ms, input logic fin);
		while (!calm && $urandom_range(99) < 27) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		func         <= f;
		button_down  <= btn;
		ms_strobe    <= ms;
		entry_mode   <= m;
		entry_step   <= s;
		entry_output <= o;
		entry_level  <= lvl;
		entry_wait   <= hold_ms;
		entry_final  <= fin;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		items_sent++;
	endtask

	task automatic tick(input logic btn, input logic ms);
		send_request(lps_pkg::FUNC_TICK, btn, ms, MODE_W'($urandom), STEP_W'($urandom),
			3'($urandom), 1'($urandom), 16'($urandom), 1'($urandom));
	endtask

	// Write an entry; force the final mark where the next step is still unwritten
	task automatic write_entry(input int m, input int s, input int o, input int lvl,
			input int hold_ms, input int fin);
		logic fin_v;
		fin_v = (fin != 0);
		if (!fin_v && s != lps_pkg::DEF_MAX_STEPS-1 && !entry_known[m][s+1])
			fin_v = 1'b1;
		entry_known[m][s] = 1'b1;
		send_request(lps_pkg::FUNC_WRITE, 1'($urandom), 1'($urandom), MODE_W'(m),
			STEP_W'(s), 3'(o), 1'(lvl), 16'(hold_ms), fin_v);
	endtask

	function automatic int pick_hold();
		int r;
		r = int'($urandom_range(99));
		if (r < 80)
			return int'($urandom_range(0, 3));
		else if (r < 95)
			return int'($urandom_range(4, 40));
		return int'($urandom_range(0, 65535));
	endfunction

	// Load a well-formed pattern, last entry first
	task automatic load_pattern();
		int m;
		int n;
		m = int'($urandom_range(lps_pkg::DEF_MAX_PATTERNS-1));
		n = int'($urandom_range(1, 8));
		for (int i = n-1; i >= 0; i--)
			write_entry(m, i, int'($urandom_range(7)), int'($urandom_range(1)), pick_hold(),
				(i == n-1) ? 1 : 0);
	endtask

	// Hold the button long enough to count (mostly), then release
	task automatic play_run();
		int hold_len;
		int rest_len;
		hold_len = ((debounce_now == 0) ? 1 : debounce_now) + int'($urandom_range(0, 3));
		if ($urandom_range(3) == 0)
			hold_len = int'($urandom_range(0, 1));
		rest_len = int'($urandom_range(3, 25));
		repeat (hold_len) tick(1'b1, $urandom_range(99) < 70);
		repeat (rest_len) tick(1'b0, $urandom_range(99) < 70);
	endtask

	task automatic run_phase(input int n);
		int goal;
		int r;
		goal = items_sent + n;
		while (items_sent < goal) begin
			r = int'($urandom_range(99));
			if (r < 30) begin
				load_pattern();
			end else if (r < 85) begin
				play_run();
			end else begin
				repeat ($urandom_range(1, 4)) begin
					if ($urandom_range(1))
						tick(1'($urandom), 1'($urandom));
					else
						write_entry(int'($urandom_range(7)), int'($urandom_range(63)),
							int'($urandom_range(7)), int'($urandom_range(1)),
							int'($urandom_range(65535)), int'($urandom_range(1)));
				end
			end
		end
	endtask

	// Drop valid and wait for every outstanding result
	task automatic wait_idle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input logic [lps_pkg::CFG_IDX_W-1:0] idx,
			input logic [lps_pkg::CFG_DATA_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		if (idx == lps_pkg::REG_DEBOUNCE_LIMIT)
			debounce_now = int'(val);
		@(posedge clk);
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Seed step 0 of every pattern so any mode can play
		write_entry(0, 0, 0, 1, 0, 1);
		write_entry(1, 0, 6, 1, 2, 1);
		write_entry(2, 0, 7, 1, 3, 1);  // output beyond the LED bank
		write_entry(3, 0, 1, 1, 0, 1);
		write_entry(4, 0, 2, 0, 1, 1);
		write_entry(5, 0, 3, 1, 0, 1);
		write_entry(6, 0, 4, 1, 0, 1);
		write_entry(7, 0, 5, 1, 65535, 1);
		write_entry(7, 63, 2, 1, 0, 0);
		// two-step pattern in mode 0
		write_entry(0, 1, 6, 1, 1, 1);
		write_entry(0, 0, 0, 1, 0, 0);
		tick(1'b0, 1'b0);
		tick(1'b0, 1'b1);
		tick(1'b0, 1'b1);
		tick(1'b0, 1'b0);
		tick(1'b1, 1'b1);
		tick(1'b1, 1'b1);
		tick(1'b1, 1'b0);
		tick(1'b0, 1'b1);
		tick(1'b0, 1'b1);
		tick(1'b0, 1'b1);
		wait_idle();

		// Fast debounce, all patterns, no gaps at all
		set_config(lps_pkg::REG_DEBOUNCE_LIMIT, 8'd1);
		set_config(lps_pkg::REG_MODE_COUNT, 8'd8);
		calm = 1'b1;
		run_phase(70);
		calm = 1'b0;
		wait_idle();

		// Three patterns, long result hold-off while requests keep coming
		set_config(lps_pkg::REG_DEBOUNCE_LIMIT, 8'd3);
		set_config(lps_pkg::REG_MODE_COUNT, 8'd3);
		hold_armed = 1'b1;
		run_phase(70);
		wait_idle();

		// Longest debounce: one full press, button left down at the end
		set_config(lps_pkg::REG_DEBOUNCE_LIMIT, 8'd255);
		set_config(lps_pkg::REG_MODE_COUNT, 8'd8);
		repeat (258) tick(1'b1, 1'($urandom_range(1)));
		load_pattern();
		repeat (5) tick(1'b1, 1'($urandom_range(1)));
		wait_idle();

		// Limit and count of zero; count clamps while the button stays down
		set_config(lps_pkg::REG_DEBOUNCE_LIMIT, 8'd0);
		set_config(lps_pkg::REG_MODE_COUNT, 8'd0);
		repeat (3) tick(1'b1, 1'b1);
		tick(1'b0, 1'b0);
		// full-length pattern in mode 0 with no final mark, so the step wraps
		for (int s = lps_pkg::DEF_MAX_STEPS-1; s >= 0; s--)
			write_entry(0, s, s % 8, int'($urandom_range(1)), (s % 4 == 0) ? 1 : 0, 0);
		tick(1'b1, 1'b1);
		repeat (100) tick(1'b0, 1'($urandom_range(1)));
		run_phase(30);
		wait_idle();

		// Count above the table size
		set_config(lps_pkg::REG_DEBOUNCE_LIMIT, 8'd2);
		set_config(lps_pkg::REG_MODE_COUNT, 8'd15);
		run_phase(80);
		wait_idle();

		// Count lowered under the current mode; upper data bits ignored
		set_config(lps_pkg::REG_DEBOUNCE_LIMIT, 8'd5);
		set_config(lps_pkg::REG_MODE_COUNT, 8'hA2);
		run_phase(70);
		wait_idle();

		repeat (10) @(posedge clk);
		if (error_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// ===== led_pattern_sequencer.f =====
rtl/core/lps_pkg.sv
rtl/core/led_pattern_sequencer.sv
rtl/core/lps_chk.sv
bench/led_pattern_sequencer_checker.sv
bench/led_pattern_sequencer_tb.sv
